// ----- rtl/pdbw_pkg.sv -----
// Package for the pair distance / histogram bin block.
// Item types, field widths and the shared abs_diff arithmetic helper; no dependencies.
`timescale 1ns / 1ps

package pdbw_pkg;

  localparam int CoordW  = 24;
  localparam int WeightW = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int SumW    = SqW;
  localparam int RootW   = 25;
  localparam int InvW    = 16;
  localparam int ProdW   = 32;
  localparam int BinW    = 25;
  localparam int BinProdW = RootW + InvW;
  localparam int BinShift = 16;

  localparam logic [InvW-1:0]     InvReset  = 16'd5120;
  localparam logic [BinProdW:0]   RoundBias = (BinProdW + 1)'(1) << (BinShift - 1);

  typedef struct packed {
    logic signed [CoordW-1:0]  first_x;
    logic signed [CoordW-1:0]  first_y;
    logic signed [CoordW-1:0]  first_z;
    logic signed [WeightW-1:0] first_weight;
    logic signed [CoordW-1:0]  second_x;
    logic signed [CoordW-1:0]  second_y;
    logic signed [CoordW-1:0]  second_z;
    logic signed [WeightW-1:0] second_weight;
  } in_t;

  typedef struct packed {
    logic [RootW-1:0]        distance;
    logic [BinW-1:0]         bin_index;
    logic signed [ProdW-1:0] weight_product;
  } out_t;

  // |a - b| of two signed coordinates, exact in DiffW bits
  function automatic logic [DiffW-1:0] abs_diff(input logic signed [CoordW-1:0] a,
                                                input logic signed [CoordW-1:0] b);
    logic signed [DiffW-1:0] d;
    d = DiffW'(a) - DiffW'(b);
    abs_diff = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

endpackage

// ----- rtl/pair_distance_bin_weight_top.sv -----
// Top level of the pair distance / histogram bin block.
// Depends on pdbw_pkg for item types, widths and the abs_diff helper.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive in_item and raise start; the item is taken at a
//   rising edge with start high and busy low. busy is always low, so one
//   item can be taken in every cycle.
//   Result channel: out_valid strobes for one cycle with out_item; the
//   receiver must take it then, it cannot hold results off.
//   Config: cfg_we with cfg_wdata writes the inverse bin width (Q0.16).
//   Write it only while no item is in flight.
//   Throughput is one item per cycle: a 30-stage pipeline (difference,
//   square, sum, 25 one-bit square-root stages, bin multiply, rounding)
//   with a valid bit carried alongside each stage; out_valid is the valid
//   bit of the last stage.
//   Reset (rst_n low, synchronous): all valid bits clear, in-flight items
//   are dropped and the inverse bin width returns to 0.078125 (5120).
module pair_distance_bin_weight_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pdbw_pkg::in_t                 in_item,
  output logic                          out_valid,
  output pdbw_pkg::out_t                out_item,
  input  logic                          cfg_we,
  input  logic [pdbw_pkg::InvW-1:0]     cfg_wdata
);

  localparam int DiffW    = pdbw_pkg::DiffW;
  localparam int SqW      = pdbw_pkg::SqW;
  localparam int SumW     = pdbw_pkg::SumW;
  localparam int RootW    = pdbw_pkg::RootW;
  localparam int ProdW    = pdbw_pkg::ProdW;
  localparam int WeightW  = pdbw_pkg::WeightW;
  localparam int BinW     = pdbw_pkg::BinW;
  localparam int BinProdW = pdbw_pkg::BinProdW;

  logic [pdbw_pkg::InvW-1:0] inv_width_r;
  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_width_r <= pdbw_pkg::InvReset;
    end else if (cfg_we) begin
      inv_width_r <= cfg_wdata;
    end
  end

  // stage 1: absolute differences
  logic                      s1_valid_r;
  logic [DiffW-1:0]          s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [WeightW-1:0] s1_w1_r, s1_w2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_dx_r <= pdbw_pkg::abs_diff(in_item.first_x, in_item.second_x);
    s1_dy_r <= pdbw_pkg::abs_diff(in_item.first_y, in_item.second_y);
    s1_dz_r <= pdbw_pkg::abs_diff(in_item.first_z, in_item.second_z);
    s1_w1_r <= in_item.first_weight;
    s1_w2_r <= in_item.second_weight;
  end

  // stage 2: squares and weight product
  logic                    s2_valid_r;
  logic [SqW-1:0]          s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic signed [ProdW-1:0] s2_wprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_sqx_r   <= SqW'(s1_dx_r) * SqW'(s1_dx_r);
    s2_sqy_r   <= SqW'(s1_dy_r) * SqW'(s1_dy_r);
    s2_sqz_r   <= SqW'(s1_dz_r) * SqW'(s1_dz_r);
    s2_wprod_r <= ProdW'(s1_w1_r) * ProdW'(s1_w2_r);
  end

  // stage 3 (root stage 0): squared distance
  logic                    sq_valid_r [RootW+1];
  logic [SumW-1:0]         sq_rem_r   [RootW+1];
  logic [RootW-1:0]        sq_root_r  [RootW+1];
  logic signed [ProdW-1:0] sq_wprod_r [RootW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else begin
      sq_valid_r[0] <= s2_valid_r;
    end
    sq_rem_r[0]   <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
    sq_root_r[0]  <= '0;
    sq_wprod_r[0] <= s2_wprod_r;
  end

  // floor square root, one result bit per stage, MSB first
  for (genvar k = 0; k < RootW; k++) begin : g_root
    localparam int Bit = RootW - 1 - k;
    logic [SumW-1:0] trial;

    // (q + 2^Bit)^2 - q^2, q holding only bits above Bit
    assign trial = (SumW'(sq_root_r[k]) << (Bit + 1)) | (SumW'(1) << (2 * Bit));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
      if (sq_rem_r[k] >= trial) begin
        sq_rem_r[k+1]  <= sq_rem_r[k] - trial;
        sq_root_r[k+1] <= sq_root_r[k] | (RootW'(1) << Bit);
      end else begin
        sq_rem_r[k+1]  <= sq_rem_r[k];
        sq_root_r[k+1] <= sq_root_r[k];
      end
      sq_wprod_r[k+1] <= sq_wprod_r[k];
    end
  end

  // bin multiply
  logic                    mul_valid_r;
  logic [BinProdW-1:0]     mul_prod_r;
  logic [RootW-1:0]        mul_dist_r;
  logic signed [ProdW-1:0] mul_wprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= sq_valid_r[RootW];
    end
    mul_prod_r  <= BinProdW'(sq_root_r[RootW]) * BinProdW'(inv_width_r);
    mul_dist_r  <= sq_root_r[RootW];
    mul_wprod_r <= sq_wprod_r[RootW];
  end

  // round half up and output register
  logic                 out_valid_r;
  pdbw_pkg::out_t       out_item_r;
  logic [BinProdW:0]    rounded;

  assign rounded = (BinProdW + 1)'(mul_prod_r) + pdbw_pkg::RoundBias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_valid_r;
    end
    out_item_r.distance       <= mul_dist_r;
    out_item_r.bin_index      <= rounded[pdbw_pkg::BinShift +: BinW];
    out_item_r.weight_product <= mul_wprod_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
